// ----- hw/rtl/ccv_pkg.sv -----
// ----------------------------------------------------------------------------
// ccv_pkg
// Types, codes and constants shared by the colour coherence vector core.
// ----------------------------------------------------------------------------
package ccv_pkg;

  localparam int CNT_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam logic [CNT_W-1:0] CNT_SAT = 17'h1FFFF;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_READ   = 1'b1;
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BPC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WID = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HGT = 2'd3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic       last_pixel;
    logic [8:0] bin_select;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [CNT_W-1:0] coherent_count;
    logic [CNT_W-1:0] incoherent_count;
    logic [CNT_W-1:0] region_total;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CLR,
    S_SEED,
    S_SEED_CHK,
    S_POP,
    S_POP_TAKE,
    S_NB,
    S_NB_CHK,
    S_HIST_RD,
    S_HIST_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic out_read;
    logic clr_step;
    logic seed_rd;
    logic seed_chk;
    logic pop_rd;
    logic pop_take;
    logic nb_issue;
    logic nb_chk;
    logic hist_rd;
    logic hist_wr;
    logic out_done;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic seed_end;
    logic seed_visited;
    logic q_empty;
    logic nb_ok;
    logic nb_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/color_coherence_vector_core.sv -----
// ----------------------------------------------------------------------------
// color_coherence_vector_core
// Colour coherence vector engine with 8-connected region flood.
// ----------------------------------------------------------------------------
//  channel | ports                            | carries
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_item      | pixel load or bin read request
//  out     | out_valid, out_ready, out_item   | done or bin read result
//  cfg     | cfg_valid, cfg_ready, cfg_index, | register writes, always ready
//          | cfg_data                         |
//
// pixel loads are taken back to back while idle; a bin read result passes
// from the histogram read register through S_RD to the output register.
// after the last pixel the visited map and histograms are cleared by a
// sweep over max(width*height, 512) addresses, then the seed scan tests each
// pixel and floods each unvisited one: pops, neighbor checks, an empty queue
// check and a histogram update per region, and the done result at the end.
// requests wait for S_IDLE and a free output. reset is synchronous; memories
// hold no reset, and only visited map and histograms are swept per image.
module color_coherence_vector_core import ccv_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_BPC    = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  ccv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts)
  );

  ccv_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BPC    (MAX_BPC)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- hw/rtl/ccv_ctrl.sv -----
// ----------------------------------------------------------------------------
// ccv_ctrl
// Sequencer for pixel loading, bin reads and the region flood.
// ----------------------------------------------------------------------------
module ccv_ctrl import ccv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output dp_cmd_t    cmd,
  input  dp_status_t sts
);

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_item.opcode == OP_READ) begin
            state_nxt = S_RD;
          end else if (in_item.last_pixel) begin
            state_nxt = S_CLR;
          end
        end
      end
      S_RD:       state_nxt = S_IDLE;
      S_CLR:      if (sts.sweep_last) state_nxt = S_SEED;
      S_SEED:     state_nxt = sts.seed_end ? S_DONE : S_SEED_CHK;
      S_SEED_CHK: state_nxt = sts.seed_visited ? S_SEED : S_POP;
      S_POP:      state_nxt = sts.q_empty ? S_HIST_RD : S_POP_TAKE;
      S_POP_TAKE: state_nxt = S_NB;
      S_NB: begin
        if (sts.nb_ok) begin
          state_nxt = S_NB_CHK;
        end else if (sts.nb_last) begin
          state_nxt = S_POP;
        end
      end
      S_NB_CHK:   state_nxt = sts.nb_last ? S_POP : S_NB;
      S_HIST_RD:  state_nxt = S_HIST_WR;
      S_HIST_WR:  state_nxt = S_SEED;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = in_fire && (in_item.opcode == OP_LOAD);
    cmd.rd_issue = in_fire && (in_item.opcode == OP_READ);
    case (state_r)
      S_RD:       cmd.out_read = 1'b1;
      S_CLR:      cmd.clr_step = 1'b1;
      S_SEED:     cmd.seed_rd  = !sts.seed_end;
      S_SEED_CHK: cmd.seed_chk = 1'b1;
      S_POP:      cmd.pop_rd   = !sts.q_empty;
      S_POP_TAKE: cmd.pop_take = 1'b1;
      S_NB:       cmd.nb_issue = 1'b1;
      S_NB_CHK:   cmd.nb_chk   = 1'b1;
      S_HIST_RD:  cmd.hist_rd  = 1'b1;
      S_HIST_WR:  cmd.hist_wr  = 1'b1;
      S_DONE:     cmd.out_done = 1'b1;
      default:    cmd.load     = cmd.load;
    endcase
  end

endmodule

// ----- hw/rtl/ccv_datapath.sv -----
// ----------------------------------------------------------------------------
// ccv_datapath
// Pixel store, visited map, flood queue, histograms and result register.
// ----------------------------------------------------------------------------
module ccv_datapath import ccv_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_BPC    = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  input  dp_cmd_t              cmd,
  output dp_status_t           sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CLW   = 3 * MAX_BPC;
  localparam int NBINS = 1 << CLW;
  localparam int SWW   = (PW > CLW + 1) ? PW : CLW + 1;
  localparam int SUMW  = ((PW > CNT_W) ? PW : CNT_W) + 1;
  localparam int QW    = AW + YW + XW;

  // configuration
  logic [1:0]       bpc_r;
  logic [CNT_W-1:0] thr_r;
  logic [8:0]       wid_r, hgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpc_r <= 2'd2;
      thr_r <= 17'd4;
      wid_r <= 9'd256;
      hgt_r <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BPC: bpc_r <= cfg_data[1:0];
        REG_THR: thr_r <= cfg_data;
        REG_WID: wid_r <= cfg_data[8:0];
        REG_HGT: hgt_r <= cfg_data[8:0];
        default: bpc_r <= bpc_r;
      endcase
    end
  end

  logic [1:0]    bpc_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [PW-1:0] n_pix;

  always_comb begin
    if (bpc_r == 2'd0) bpc_eff = 2'd1;
    else if (32'(bpc_r) > MAX_BPC) bpc_eff = 2'(MAX_BPC);
    else bpc_eff = bpc_r;
    if (wid_r == 9'd0) w_eff = WW'(1);
    else if (32'(wid_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(wid_r);
    if (hgt_r == 9'd0) h_eff = HW'(1);
    else if (32'(hgt_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(hgt_r);
  end

  assign n_pix = PW'(w_eff) * PW'(h_eff);

  // quantized colour of the incoming pixel
  logic [3:0]     qshift;
  logic [7:0]     q0, q1, q2;
  logic [CLW-1:0] in_colour;

  always_comb begin
    qshift    = 4'd8 - {2'b00, bpc_eff};
    q0        = in_item.chan0 >> qshift;
    q1        = in_item.chan1 >> qshift;
    q2        = in_item.chan2 >> qshift;
    in_colour = CLW'((32'(q0) << {bpc_eff, 1'b0}) | (32'(q1) << bpc_eff) | 32'(q2));
  end

  // control registers of the flood
  logic [PW-1:0]    pos_r, p_r, head_r, tail_r, size_r;
  logic [SWW-1:0]   sweep_r;
  logic [YW-1:0]    sr_r, cur_r, nr_r;
  logic [XW-1:0]    sc_r, cur_c, nc_r;
  logic [AW-1:0]    cur_p;
  logic [PW-1:0]    q_nb_r;
  logic [2:0]       k_r;
  logic [CLW-1:0]   colour_r;
  logic [CNT_W-1:0] regions_r;
  logic             hist_zero_r, rd_zero_r;

  // memory read data
  logic [CLW-1:0]   pix_rd_r;
  logic             vis_rd_r;
  logic [QW-1:0]    q_rd_r;
  logic [CNT_W-1:0] coh_rd_r, inc_rd_r;

  // neighbor geometry
  logic          up, down, left, right, nb_ok;
  logic [PW-1:0] row_off, col_off, q_nb;
  logic [YW-1:0] nr;
  logic [XW-1:0] nc;

  always_comb begin
    up    = k_r < 3'd3;
    down  = k_r > 3'd4;
    left  = (k_r == 3'd0) || (k_r == 3'd3) || (k_r == 3'd5);
    right = (k_r == 3'd2) || (k_r == 3'd4) || (k_r == 3'd7);
    nb_ok = !(up && cur_r == '0) && !(down && (HW'(cur_r) + HW'(1) == h_eff)) &&
            !(left && cur_c == '0) && !(right && (WW'(cur_c) + WW'(1) == w_eff));
    row_off = up ? (PW'(0) - PW'(w_eff)) : (down ? PW'(w_eff) : '0);
    col_off = left ? '1 : (right ? PW'(1) : '0);
    q_nb    = PW'(cur_p) + row_off + col_off;
    nr      = up ? cur_r - YW'(1) : (down ? cur_r + YW'(1) : cur_r);
    nc      = left ? cur_c - XW'(1) : (right ? cur_c + XW'(1) : cur_c);
  end

  logic [SWW-1:0] sweep_lim;
  logic           seed_col_last, match;
  assign sweep_lim     = (SWW'(n_pix) > SWW'(NBINS)) ? SWW'(n_pix) : SWW'(NBINS);
  assign seed_col_last = (WW'(sc_r) + WW'(1) == w_eff);
  assign match         = !vis_rd_r && (pix_rd_r == colour_r);

  // histogram update values
  logic [SUMW-1:0]  coh_sum, inc_sum;
  logic [CNT_W-1:0] coh_new, inc_new;
  logic             is_coh;
  always_comb begin
    is_coh  = SUMW'(size_r) > SUMW'(thr_r);
    coh_sum = SUMW'(coh_rd_r) + SUMW'(size_r);
    inc_sum = SUMW'(inc_rd_r) + SUMW'(size_r);
    coh_new = (coh_sum > SUMW'(CNT_SAT)) ? CNT_SAT : CNT_W'(coh_sum);
    inc_new = (inc_sum > SUMW'(CNT_SAT)) ? CNT_SAT : CNT_W'(inc_sum);
  end

  // memory ports
  logic [AW-1:0]    pv_ra, vis_wa, q_wa;
  logic             vis_we, vis_wd, q_we;
  logic [QW-1:0]    q_wd;
  logic [CLW-1:0]   h_ra, h_wa;
  logic             coh_we, inc_we;
  logic [CNT_W-1:0] coh_wd, inc_wd;
  logic [3:0]       bin_shamt;
  logic             bin_out;

  always_comb begin
    pv_ra  = cmd.seed_rd ? p_r[AW-1:0] : q_nb[AW-1:0];
    vis_we = 1'b0;
    vis_wa = q_nb_r[AW-1:0];
    vis_wd = 1'b1;
    q_we   = 1'b0;
    q_wa   = tail_r[AW-1:0];
    q_wd   = {q_nb_r[AW-1:0], nr_r, nc_r};
    if (cmd.clr_step) begin
      vis_we = sweep_r < SWW'(n_pix);
      vis_wa = sweep_r[AW-1:0];
      vis_wd = 1'b0;
    end else if (cmd.seed_chk) begin
      vis_we = !vis_rd_r;
      vis_wa = p_r[AW-1:0];
      q_we   = !vis_rd_r;
      q_wa   = '0;
      q_wd   = {p_r[AW-1:0], sr_r, sc_r};
    end else if (cmd.nb_chk) begin
      vis_we = match;
      q_we   = match;
    end
    h_ra   = cmd.rd_issue ? CLW'(in_item.bin_select) : colour_r;
    h_wa   = cmd.clr_step ? sweep_r[CLW-1:0] : colour_r;
    coh_we = (cmd.clr_step && sweep_r < SWW'(NBINS)) || (cmd.hist_wr && is_coh);
    inc_we = (cmd.clr_step && sweep_r < SWW'(NBINS)) || (cmd.hist_wr && !is_coh);
    coh_wd = cmd.clr_step ? '0 : coh_new;
    inc_wd = cmd.clr_step ? '0 : inc_new;
    bin_shamt = 4'd3 * {2'b00, bpc_eff};
    bin_out   = (in_item.bin_select >> bin_shamt) != 9'd0;
  end

  logic [CLW-1:0]   pix_mem [DEPTH];
  logic             vis_mem [DEPTH];
  logic [QW-1:0]    q_mem   [DEPTH];
  logic [CNT_W-1:0] coh_mem [NBINS];
  logic [CNT_W-1:0] inc_mem [NBINS];

  always_ff @(posedge clk) begin
    if (cmd.load && pos_r < n_pix) pix_mem[pos_r[AW-1:0]] <= in_colour;
    pix_rd_r <= pix_mem[pv_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd_r <= vis_mem[pv_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_r <= q_mem[head_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (coh_we) coh_mem[h_wa] <= coh_wd;
    if (inc_we) inc_mem[h_wa] <= inc_wd;
    coh_rd_r <= coh_mem[h_ra];
    inc_rd_r <= inc_mem[h_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hist_zero_r <= 1'b1;
      out_valid   <= 1'b0;
      sweep_r     <= '0;
      p_r         <= '0;
      sr_r        <= '0;
      sc_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      size_r      <= '0;
      k_r         <= '0;
      regions_r   <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        if (pos_r == '0) hist_zero_r <= 1'b1;
        pos_r   <= (pos_r < n_pix) ? pos_r + PW'(1) : n_pix;
        sweep_r <= '0;
      end
      if (cmd.clr_step) begin
        sweep_r <= sweep_r + SWW'(1);
        if (sweep_r == sweep_lim - SWW'(1)) begin
          p_r         <= '0;
          sr_r        <= '0;
          sc_r        <= '0;
          regions_r   <= '0;
          hist_zero_r <= 1'b0;
        end
      end
      if ((cmd.seed_chk && vis_rd_r) || cmd.hist_wr) begin
        p_r <= p_r + PW'(1);
        if (seed_col_last) begin
          sc_r <= '0;
          sr_r <= sr_r + YW'(1);
        end else begin
          sc_r <= sc_r + XW'(1);
        end
      end
      if (cmd.seed_chk && !vis_rd_r) begin
        head_r <= '0;
        tail_r <= PW'(1);
        size_r <= '0;
      end
      if (cmd.pop_rd) head_r <= head_r + PW'(1);
      if (cmd.pop_take) begin
        size_r <= size_r + PW'(1);
        k_r    <= '0;
      end
      if (cmd.nb_issue && !nb_ok) k_r <= k_r + 3'd1;
      if (cmd.nb_chk) begin
        k_r <= k_r + 3'd1;
        if (match) tail_r <= tail_r + PW'(1);
      end
      if (cmd.hist_wr && regions_r != CNT_SAT) regions_r <= regions_r + CNT_W'(1);
      if (cmd.out_done || cmd.out_read) out_valid <= 1'b1;
      if (cmd.out_done) pos_r <= '0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_zero_r <= hist_zero_r || bin_out;
    if (cmd.seed_chk) colour_r <= pix_rd_r;
    if (cmd.pop_take) {cur_p, cur_r, cur_c} <= q_rd_r;
    if (cmd.nb_issue) begin
      q_nb_r <= q_nb;
      nr_r   <= nr;
      nc_r   <= nc;
    end
    if (cmd.out_done) begin
      out_item.result_kind      <= KIND_DONE;
      out_item.coherent_count   <= '0;
      out_item.incoherent_count <= '0;
      out_item.region_total     <= regions_r;
    end else if (cmd.out_read) begin
      out_item.result_kind      <= KIND_READ;
      out_item.coherent_count   <= rd_zero_r ? '0 : coh_rd_r;
      out_item.incoherent_count <= rd_zero_r ? '0 : inc_rd_r;
      out_item.region_total     <= '0;
    end
  end

  always_comb begin
    sts.sweep_last   = sweep_r == sweep_lim - SWW'(1);
    sts.seed_end     = p_r == n_pix;
    sts.seed_visited = vis_rd_r;
    sts.q_empty      = head_r == tail_r;
    sts.nb_ok        = nb_ok;
    sts.nb_last      = k_r == 3'd7;
    sts.out_free     = !out_valid || out_ready;
  end

endmodule

// ----- sim/color_coherence_vector_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_coherence_vector_core_tb
// Loads small images and bin reads into the core under random back-pressure,
// predicts the region counts and histograms with its own flood search and
// checks every done and read result field by field.
// ----------------------------------------------------------------------------
module color_coherence_vector_core_tb;
  import ccv_pkg::*;

  localparam int PIX_MAX = 65536;
  localparam int BIN_MAX = 512;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BPC;
  logic [CNT_W-1:0]     cfg_data = '0;

  color_coherence_vector_core dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [1:0]       bpc_reg = 2'd2;
  logic [CNT_W-1:0] thr_reg = 17'd4;
  logic [8:0]       wid_reg = 9'd256;
  logic [8:0]       hgt_reg = 9'd256;
  logic [8:0]       pix_colour [PIX_MAX];
  bit               seen [PIX_MAX];
  int               flood_fifo [PIX_MAX];
  logic [CNT_W-1:0] coh_hist [BIN_MAX];
  logic [CNT_W-1:0] incoh_hist [BIN_MAX];
  int               load_pos = 0;

  in_item_t  pending_requests [$];
  out_item_t expected_results [$];
  int        requests_sent = 0;
  int        errors = 0;
  bit        quiet = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;

  function automatic void add_request(in_item_t r);
    pending_requests = {pending_requests, r};
  endfunction

  function automatic int eff_bpc();
    return (bpc_reg < 1) ? 1 : (bpc_reg > 3) ? 3 : int'(bpc_reg);
  endfunction
  function automatic int eff_wid();
    return (wid_reg < 1) ? 1 : (wid_reg > 256) ? 256 : int'(wid_reg);
  endfunction
  function automatic int eff_hgt();
    return (hgt_reg < 1) ? 1 : (hgt_reg > 256) ? 256 : int'(hgt_reg);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] a, int b);
    longint s;
    s = longint'(a) + b;
    return (s > CNT_SAT) ? CNT_SAT : s[CNT_W-1:0];
  endfunction

  // breadth-first 8-connected flood over every seed in row-major order
  function automatic logic [CNT_W-1:0] count_regions();
    int w, h, n, head, tail, sz, r, c, nr, nc, q, p;
    logic [8:0] col;
    logic [CNT_W-1:0] regions;
    w = eff_wid();
    h = eff_hgt();
    n = w * h;
    regions = '0;
    for (p = 0; p < n; p++) begin
      if (!seen[p]) begin
        col = pix_colour[p];
        seen[p] = 1'b1;
        head = 0;
        tail = 1;
        sz = 0;
        flood_fifo[0] = p;
        while (head < tail) begin
          r = flood_fifo[head] / w;
          c = flood_fifo[head] % w;
          head++;
          sz++;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              nr = r + dr;
              nc = c + dc;
              if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < h && nc < w) begin
                q = nr * w + nc;
                if (!seen[q] && pix_colour[q] == col) begin
                  seen[q] = 1'b1;
                  flood_fifo[tail++] = q;
                end
              end
            end
          end
        end
        if (sz > thr_reg) coh_hist[col] = sat_inc(coh_hist[col], sz);
        else incoh_hist[col] = sat_inc(incoh_hist[col], sz);
        regions = sat_inc(regions, 1);
      end
    end
    return regions;
  endfunction

  task automatic predict_request(in_item_t r);
    int b, n;
    logic [8:0] col;
    out_item_t e;
    b = eff_bpc();
    e = '0;
    if (r.opcode == OP_READ) begin
      e.result_kind = KIND_READ;
      if (r.bin_select < (1 << (3 * b))) begin
        e.coherent_count = coh_hist[r.bin_select];
        e.incoherent_count = incoh_hist[r.bin_select];
      end
      expected_results = {expected_results, e};
    end else begin
      n = eff_wid() * eff_hgt();
      col = 9'((int'(r.chan0) >> (8 - b)) << (2 * b) | (int'(r.chan1) >> (8 - b)) << b
               | (int'(r.chan2) >> (8 - b)));
      if (load_pos == 0) begin
        foreach (seen[i]) seen[i] = 1'b0;
        foreach (coh_hist[i]) begin
          coh_hist[i] = '0;
          incoh_hist[i] = '0;
        end
      end
      if (load_pos < n) pix_colour[load_pos++] = col;
      else load_pos = n;
      if (r.last_pixel) begin
        e.result_kind = KIND_DONE;
        e.region_total = count_regions();
        load_pos = 0;
        expected_results = {expected_results, e};
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_item);
        requests_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_item <= pending_requests.pop_front();
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result kind=%0d", out_item.result_kind);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_item.result_kind !== e.result_kind) begin
            $error("result_kind exp %0d got %0d", e.result_kind, out_item.result_kind);
            errors++;
          end
          if (out_item.coherent_count !== e.coherent_count) begin
            $error("coherent_count exp %0d got %0d", e.coherent_count,
                   out_item.coherent_count);
            errors++;
          end
          if (out_item.incoherent_count !== e.incoherent_count) begin
            $error("incoherent_count exp %0d got %0d", e.incoherent_count,
                   out_item.incoherent_count);
            errors++;
          end
          if (out_item.region_total !== e.region_total) begin
            $error("region_total exp %0d got %0d", e.region_total, out_item.region_total);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) out_gap = $urandom_range(1, 5);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BPC: bpc_reg = val[1:0];
      REG_THR: thr_reg = val;
      REG_WID: wid_reg = val[8:0];
      default: hgt_reg = val[8:0];
    endcase
  endtask

  // checked away from the rising edge so the driver's updates have settled
  task automatic drain();
    forever begin
      @(negedge clk);
      if (pending_requests.size() == 0 && !in_valid && expected_results.size() == 0) break;
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t load_req(logic [23:0] rgb, bit last);
    in_item_t r;
    r = in_item_t'($urandom);
    r.opcode = OP_LOAD;
    {r.chan0, r.chan1, r.chan2} = rgb;
    r.last_pixel = last;
    return r;
  endfunction

  function automatic in_item_t read_req(int bin);
    in_item_t r;
    r = in_item_t'($urandom);
    r.opcode = OP_READ;
    r.bin_select = 9'(bin);
    return r;
  endfunction

  // whole image from a small palette so regions form, plus surplus pixels
  task automatic queue_image(int extra);
    logic [23:0] palette [4];
    int n, k;
    n = eff_wid() * eff_hgt();
    k = $urandom_range(1, 4);
    foreach (palette[i]) palette[i] = $urandom;
    for (int i = 0; i < n + extra; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_request(load_req($urandom, i == n + extra - 1));
      else
        add_request(load_req(palette[$urandom_range(0, k - 1)], i == n + extra - 1));
    end
  endtask

  task automatic queue_reads(int cnt);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 3) == 0)
        add_request(read_req($urandom_range(0, 511)));
      else
        add_request(read_req($urandom_range(0, (1 << (3 * eff_bpc())) - 1)));
    end
  endtask

  initial begin
    int w, h;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reads on empty histograms, including out-of-range bins
    add_request(read_req(0));
    add_request(read_req(511));
    drain();

    // single pixel image at channel extremes, low clamps
    write_reg(REG_WID, 17'd0);
    write_reg(REG_HGT, 17'd0);
    write_reg(REG_THR, 17'd0);
    write_reg(REG_BPC, 17'd0);
    add_request(load_req(24'hFFFFFF, 1'b1));
    add_request(read_req(7));
    add_request(read_req(8));
    drain();

    // 2x2 with surplus pixels, high threshold
    write_reg(REG_BPC, 17'd3);
    write_reg(REG_THR, 17'h1FFFF);
    write_reg(REG_WID, 17'd2);
    write_reg(REG_HGT, 17'd2);
    add_request(load_req(24'h000000, 1'b0));
    add_request(load_req(24'hFF00FF, 1'b0));
    add_request(load_req(24'h00FF00, 1'b0));
    add_request(load_req(24'h000000, 1'b0));
    add_request(load_req(24'hFFFFFF, 1'b0));
    add_request(load_req(24'h808080, 1'b1));
    add_request(read_req(0));
    add_request(read_req(511));
    drain();

    // quantization changed in the middle of an image
    write_reg(REG_THR, 17'd1);
    write_reg(REG_WID, 17'd3);
    write_reg(REG_HGT, 17'd1);
    add_request(load_req(24'hE0E0E0, 1'b0));
    drain();
    write_reg(REG_BPC, 17'd1);
    add_request(load_req(24'hE0E0E0, 1'b0));
    add_request(load_req(24'hE0E0E0, 1'b1));
    add_request(read_req(7));
    add_request(read_req(511));
    drain();

    // wide and tall strips, high clamps
    write_reg(REG_WID, 17'd511);
    write_reg(REG_HGT, 17'd1);
    write_reg(REG_THR, 17'd65536);
    queue_image(0);
    queue_reads(2);
    drain();
    write_reg(REG_WID, 17'd1);
    write_reg(REG_HGT, 17'd256);
    write_reg(REG_THR, 17'd3);
    queue_image(1);
    queue_reads(2);
    drain();

    while (requests_sent < 700) begin
      if (requests_sent > 600) quiet = 1'b1;
      write_reg(REG_BPC, 17'($urandom_range(0, 3)));
      case ($urandom_range(0, 5))
        0: write_reg(REG_THR, 17'd0);
        1: write_reg(REG_THR, 17'($urandom));
        default: write_reg(REG_THR, 17'($urandom_range(1, 8)));
      endcase
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 10);
      h = (w > 16 || w == 0) ? $urandom_range(0, 1) : $urandom_range(1, 10);
      write_reg(REG_WID, 17'(w));
      write_reg(REG_HGT, 17'(h));
      for (int i = $urandom_range(1, 3); i > 0; i--) begin
        queue_image(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        queue_reads($urandom_range(2, 6));
      end
      drain();
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end

endmodule
